// ===== rtl/glyph_outline_path_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph outline path decoder: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_OUTLINE_PATH_DECODER_DEFINES_SVH
`define GLYPH_OUTLINE_PATH_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define GOPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gopd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define GOPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gopd check failed: next-cycle implication");

`endif

// ===== rtl/gopd_pkg.sv =====
// ----------------------------------------------------------------------------
// gopd_pkg
// Types and constants shared by the glyph outline path decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gopd_pkg;

    // Path command codes
    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_QUAD  = 2'd2,
        CMD_CLOSE = 2'd3
    } gopd_cmd_t;

    // Curve record kinds
    localparam logic [15:0] KIND_LINE = 16'd1;
    localparam logic [15:0] KIND_QUAD = 16'd2;

    // Polygon header size in bytes (length, type, start x, start y)
    localparam logic [31:0] HDR_LEN = 32'd16;

    // Result stream data width: four 33-bit coordinates padded to bytes
    localparam int M_DATA_W = 136;

    // One result before the origin is applied.
    // ax/ay: move/line target or quadratic control point (raw 16.16).
    // fx/fy with cx/cy: quadratic end point; the end is f + c, where c is
    // the round-toward-zero correction of a halved negative odd sum.
    typedef struct packed {
        gopd_cmd_t          cmd;
        logic               mal;
        logic               last;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] fx;
        logic               cx;
        logic signed [31:0] fy;
        logic               cy;
    } gopd_res_t;

    // Results caused by one input byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        gopd_res_t  first;
        gopd_res_t  second;
    } gopd_emit_t;

endpackage

`default_nettype wire

// ===== rtl/gopd_parser.sv =====
// ----------------------------------------------------------------------------
// gopd_parser
// Byte-wise outline parser: assembles little-endian fields, tracks the
// polygon length and curve records, and produces up to two results a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gopd_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept_i,
    input  wire logic [7:0]          byte_i,
    input  wire logic                last_i,
    output gopd_pkg::gopd_emit_t     emit_o
);

    typedef enum logic [2:0] {
        PH_LEN, PH_TYPE, PH_SX, PH_SY, PH_KIND, PH_COUNT, PH_PX, PH_PY
    } phase_t;

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    phase_t                   phase_reg, phase_next;
    logic [1:0]               idx_reg, idx_next;
    logic [23:0]              asm_reg, asm_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic                     bad_reg, bad_next;
    logic [15:0]              kind_reg, kind_next;
    logic [15:0]              count_reg, count_next;
    logic [15:0]              pidx_reg, pidx_next;
    logic signed [31:0]       xhold_reg, xhold_next;
    logic signed [31:0]       prevx_reg, prevx_next;
    logic signed [31:0]       prevy_reg, prevy_next;

    logic [31:0]              v;
    logic [32:0]              v_minus;
    logic                     done;
    logic                     mid;
    logic signed [32:0]       sum_x, sum_y;
    logic                     data_vld, close_vld, close_mal;
    gopd_pkg::gopd_res_t      data_res, close_res;

    // Field value with the current byte placed at its lane
    always_comb begin
        case (idx_reg)
            2'd0:    v = {24'd0, byte_i};
            2'd1:    v = {16'd0, byte_i, asm_reg[7:0]};
            2'd2:    v = {8'd0, byte_i, asm_reg[15:0]};
            default: v = {byte_i, asm_reg};
        endcase
    end

    assign v_minus = {1'b0, v} - 33'd4;
    assign sum_x   = {prevx_reg[31], prevx_reg} + {xhold_reg[31], xhold_reg};
    assign sum_y   = {prevy_reg[31], prevy_reg} + {v[31], v};
    assign mid     = ({1'b0, pidx_reg} + 17'd1) < {1'b0, count_reg};

    // Next-state and result logic for one byte
    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        pidx_next  = pidx_reg;
        xhold_next = xhold_reg;
        prevx_next = prevx_reg;
        prevy_next = prevy_reg;
        bad_next   = bad_reg;
        data_vld   = 1'b0;
        close_vld  = 1'b0;
        close_mal  = 1'b0;
        data_res   = '0;
        close_res  = '0;

        left_next = (phase_reg != PH_LEN && left_reg != '0) ?
                    left_reg - LENGTH_BITS'(1) : left_reg;

        if (phase_reg == PH_KIND || phase_reg == PH_COUNT) begin
            done = (idx_reg != 2'd0);
        end else begin
            done = (idx_reg == 2'd3);
        end

        if (!done) begin
            idx_next = idx_reg + 2'd1;
            asm_next = v[23:0];
        end else begin
            idx_next = 2'd0;
            asm_next = '0;
            case (phase_reg)
                PH_LEN: begin
                    if (v < gopd_pkg::HDR_LEN) begin
                        bad_next  = 1'b1;
                        left_next = LENGTH_BITS'(gopd_pkg::HDR_LEN - 32'd4);
                    end else if (v_minus > LEN_MAX) begin
                        bad_next  = 1'b1;
                        left_next = LEN_MAX[LENGTH_BITS-1:0];
                    end else begin
                        bad_next  = 1'b0;
                        left_next = v_minus[LENGTH_BITS-1:0];
                    end
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    phase_next = PH_SX;
                end
                PH_SX: begin
                    xhold_next = v;
                    phase_next = PH_SY;
                end
                PH_SY: begin
                    data_vld     = 1'b1;
                    data_res.cmd = gopd_pkg::CMD_MOVE;
                    data_res.mal = bad_reg;
                    data_res.ax  = xhold_reg;
                    data_res.ay  = v;
                    phase_next   = PH_KIND;
                end
                PH_KIND: begin
                    kind_next  = v[15:0];
                    phase_next = PH_COUNT;
                end
                PH_COUNT: begin
                    count_next = v[15:0];
                    pidx_next  = '0;
                    phase_next = (v[15:0] != '0) ? PH_PX : PH_KIND;
                end
                PH_PX: begin
                    xhold_next = v;
                    phase_next = PH_PY;
                end
                PH_PY: begin
                    if (kind_reg == gopd_pkg::KIND_LINE) begin
                        data_vld     = 1'b1;
                        data_res.cmd = gopd_pkg::CMD_LINE;
                        data_res.ax  = xhold_reg;
                        data_res.ay  = v;
                    end else if (kind_reg == gopd_pkg::KIND_QUAD && pidx_reg != '0) begin
                        // control is the previous point; end is the point
                        // itself or the midpoint, truncated toward zero
                        data_vld     = 1'b1;
                        data_res.cmd = gopd_pkg::CMD_QUAD;
                        data_res.ax  = prevx_reg;
                        data_res.ay  = prevy_reg;
                        if (mid) begin
                            data_res.fx = sum_x[32:1];
                            data_res.cx = sum_x[32] & sum_x[0];
                            data_res.fy = sum_y[32:1];
                            data_res.cy = sum_y[32] & sum_y[0];
                        end else begin
                            data_res.fx = xhold_reg;
                            data_res.fy = v;
                        end
                    end
                    prevx_next = xhold_reg;
                    prevy_next = v;
                    pidx_next  = pidx_reg + 16'd1;
                    phase_next = (pidx_reg + 16'd1 == count_reg) ? PH_KIND : PH_PX;
                end
                default: begin
                    phase_next = PH_LEN;
                end
            endcase
        end

        // Polygon length used up
        if (phase_next != PH_LEN && left_next == '0) begin
            close_vld  = 1'b1;
            close_mal  = bad_next || !(phase_next == PH_KIND && idx_next == 2'd0);
            phase_next = PH_LEN;
            idx_next   = 2'd0;
            asm_next   = '0;
            left_next  = '0;
            bad_next   = 1'b0;
        end

        // Buffer ends: close anything still open
        if (last_i) begin
            if (!(phase_next == PH_LEN && idx_next == 2'd0)) begin
                close_vld = 1'b1;
                close_mal = 1'b1;
            end
            phase_next = PH_LEN;
            idx_next   = 2'd0;
            asm_next   = '0;
            left_next  = '0;
            bad_next   = 1'b0;
        end

        close_res.cmd  = gopd_pkg::CMD_CLOSE;
        close_res.mal  = close_mal;
        close_res.last = 1'b1;
        data_res.last  = !close_vld;

        emit_o.count  = {1'b0, data_vld} + {1'b0, close_vld};
        emit_o.first  = data_vld ? data_res : close_res;
        emit_o.second = close_res;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN;
            idx_reg   <= '0;
            asm_reg   <= '0;
            left_reg  <= '0;
            bad_reg   <= 1'b0;
            kind_reg  <= '0;
            count_reg <= '0;
            pidx_reg  <= '0;
        end else if (accept_i) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            asm_reg   <= asm_next;
            left_reg  <= left_next;
            bad_reg   <= bad_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            pidx_reg  <= pidx_next;
        end
    end

    // Point holding registers, always written before use
    always_ff @(posedge aclk) begin
        if (accept_i) begin
            xhold_reg <= xhold_next;
            prevx_reg <= prevx_next;
            prevy_reg <= prevy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/glyph_outline_path_decoder.sv =====
// ----------------------------------------------------------------------------
// glyph_outline_path_decoder
// Decodes a native glyph outline byte stream into move, line, quadratic
// and close path commands with the pen origin applied.
// ----------------------------------------------------------------------------
// One outline byte is taken per clock. Each byte yields zero, one or two
// path commands, which go into a four-entry result queue; the result
// stream delivers one command per clock, the cycle after the byte that
// caused it at the earliest. The byte input stalls only while the queue
// holds more than two commands, so the sustained rate is one byte per
// cycle as long as the bytes average at most one command each and the
// result side keeps up; the single result port sets the ceiling.
// Origins are set via APB; the user must do so only while the stream is idle.
`default_nettype none

module glyph_outline_path_decoder #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input byte stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tlast,   // last_byte
    // command stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [32:0] end_x, [65:33] end_y, [98:66] ctrl_end_x, [131:99] ctrl_end_y,
    // [135:132] zero
    output logic [gopd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,   // last_of_run
    output logic [2:0]                         m_tuser,   // [1:0] command, [2] malformed
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic signed [31:0]    origin_x_reg, origin_y_reg;
    gopd_pkg::gopd_res_t   queue_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  s_accept, m_accept;
    gopd_pkg::gopd_emit_t  emit;
    gopd_pkg::gopd_res_t   head;
    logic [1:0]            push_cnt;
    logic signed [32:0]    ox, oy, end_x, end_y, ctrl_x, ctrl_y;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Parser
    gopd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (s_accept),
        .byte_i   (s_tdata),
        .last_i   (s_tlast),
        .emit_o   (emit)
    );

    // Configuration registers
    assign pready = 1'b1;
    assign prdata = paddr[2] ? origin_y_reg : origin_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                origin_y_reg <= pwdata;
            end else begin
                origin_x_reg <= pwdata;
            end
        end
    end

    // Result queue: room for two is needed to take a byte
    assign push_cnt   = s_accept ? emit.count : 2'd0;
    assign s_tready   = (count_reg <= CNT_W'(DEPTH - 2));
    assign m_tvalid   = (count_reg != '0);
    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(m_accept);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(m_accept);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= emit.first;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= emit.second;
        end
    end

    // Origin applied at the queue head: x adds, y subtracts
    assign head   = queue_reg[rd_ptr_reg];
    assign ox     = {origin_x_reg[31], origin_x_reg};
    assign oy     = {origin_y_reg[31], origin_y_reg};
    assign end_x  = ox + {head.ax[31], head.ax};
    assign end_y  = oy - {head.ay[31], head.ay};
    assign ctrl_x = ox + {head.fx[31], head.fx} + {32'd0, head.cx};
    assign ctrl_y = oy + ~{head.fy[31], head.fy} + {32'd0, ~head.cy};

    always_comb begin
        m_tdata = '0;
        if (head.cmd != gopd_pkg::CMD_CLOSE) begin
            m_tdata[32:0]  = end_x;
            m_tdata[65:33] = end_y;
        end
        if (head.cmd == gopd_pkg::CMD_QUAD) begin
            m_tdata[98:66]  = ctrl_x;
            m_tdata[131:99] = ctrl_y;
        end
    end

    assign m_tuser = {head.mal, head.cmd};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/gopd_checker.sv =====
// ----------------------------------------------------------------------------
// gopd_checker
// Port-level checks on the command stream of the glyph outline path decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_outline_path_decoder_defines.svh"

module gopd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gopd_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic [2:0]                    m_tuser
);

    // stalled command keeps its kind and framing
    `GOPD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser) && $stable(m_tlast))

    // close always ends the commands of its byte
    `GOPD_ASSERT_IMPLIES(a_close_last, aclk, aresetn, m_tvalid && m_tuser[1:0] == gopd_pkg::CMD_CLOSE, m_tlast)

    // close carries no coordinates
    `GOPD_ASSERT_IMPLIES(a_close_zero, aclk, aresetn, m_tvalid && m_tuser[1:0] == gopd_pkg::CMD_CLOSE, m_tdata[65:0] == '0)

    // only a quadratic carries a second coordinate pair
    `GOPD_ASSERT_IMPLIES(a_ctrl_zero, aclk, aresetn, m_tvalid && m_tuser[1:0] != gopd_pkg::CMD_QUAD, m_tdata[131:66] == '0)

endmodule

bind glyph_outline_path_decoder gopd_checker u_gopd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
